[design/mexp_pkg.sv]
// Shared command and status types for the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic load;         // capture a new word and start the base reduction
    logic mul_step;     // advance the shift-add multiplier by one bit
    logic start_sq;     // start a squaring of the running result
    logic start_mul;    // start a multiplication of the result by the base
    logic commit_base;  // store the finished product as the reduced base
    logic commit_res;   // store the finished product as the running result
    logic exp_next;     // move on to the next exponent bit
    logic out_load;     // place the final result in the output register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic mul_last;     // the multiplier is on its last bit this cycle
    logic exp_bit;      // current exponent bit
    logic exp_last;     // current exponent bit is the last one
    logic out_free;     // the output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

[design/mexp_ctrl.sv]
// Sequencing state machine for the square-and-multiply loop.
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mexp_pkg::sts_t sts_i,
  output mexp_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_REDUCE   = 5'b00010,
    ST_SQUARE   = 5'b00100,
    ST_MULTIPLY = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // A new word is taken only when no item is in flight.
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.commit_base = 1'b1;
          cmd_o.start_sq    = 1'b1;
          state_d           = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.commit_res = 1'b1;
          if (sts_i.exp_bit) begin
            cmd_o.start_mul = 1'b1;
            state_d         = ST_MULTIPLY;
          end else if (sts_i.exp_last) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.exp_next = 1'b1;
            cmd_o.start_sq = 1'b1;
          end
        end
      end
      ST_MULTIPLY: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.commit_res = 1'b1;
          if (sts_i.exp_last) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.exp_next = 1'b1;
            cmd_o.start_sq = 1'b1;
            state_d        = ST_SQUARE;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/mexp_dpath.sv]
// Datapath: modulus register, shift-add modular multiplier and result registers.
`timescale 1ns / 1ps
`default_nettype none

module mexp_dpath #(
  parameter int MOD_BITS = 27,
  parameter int EXP_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [MOD_BITS-1:0] cfg_wdata_i,
  input  wire logic [MOD_BITS-1:0] base_i,
  input  wire logic [EXP_BITS-1:0] exp_i,
  input  wire mexp_pkg::cmd_t      cmd_i,
  output mexp_pkg::sts_t           sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [MOD_BITS-1:0]      out_data_o
);

  localparam int MCW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
  localparam int ECW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int SW  = MOD_BITS + 2;

  logic [MOD_BITS-1:0] mod_q;
  logic [MOD_BITS-1:0] base_q, base_d;
  logic [MOD_BITS-1:0] res_q, res_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [ECW-1:0]      ecnt_q, ecnt_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] x_q, x_d;
  logic [MOD_BITS-1:0] y_q, y_d;
  logic [MCW-1:0]      mcnt_q, mcnt_d;
  logic                out_valid_q, out_valid_d;
  logic [MOD_BITS-1:0] out_data_q, out_data_d;

  logic [MOD_BITS-1:0] one_m;
  logic [MOD_BITS-1:0] r_upd;
  logic [MOD_BITS-1:0] acc_next;
  logic [SW-1:0]       sum, sum_m1, sum_m2, m1_ext, m2_ext;
  logic                mul_start;

  // One reduced modulo the modulus: zero only for a modulus of one.
  assign one_m = (mod_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

  // One shift-add step: 2*acc + bit*x lies below 3m, so two trial subtractions suffice.
  assign m1_ext = {2'b00, mod_q};
  assign m2_ext = {1'b0, mod_q, 1'b0};
  assign sum    = {1'b0, acc_q, 1'b0} + (y_q[MOD_BITS-1] ? {2'b00, x_q} : '0);
  assign sum_m1 = sum - m1_ext;
  assign sum_m2 = sum - m2_ext;

  always_comb begin
    if (sum >= m2_ext) begin
      acc_next = sum_m2[MOD_BITS-1:0];
    end else if (sum >= m1_ext) begin
      acc_next = sum_m1[MOD_BITS-1:0];
    end else begin
      acc_next = sum[MOD_BITS-1:0];
    end
  end

  // Running result as it stands after this cycle's commit.
  assign r_upd     = cmd_i.commit_res ? acc_next : res_q;
  assign mul_start = cmd_i.load | cmd_i.start_sq | cmd_i.start_mul;

  // Multiplier operand and counter control.
  always_comb begin
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    mcnt_d = mcnt_q;
    if (mul_start) begin
      acc_d  = '0;
      mcnt_d = '0;
      if (cmd_i.load) begin
        x_d = one_m;
        y_d = base_i;
      end else if (cmd_i.start_mul) begin
        x_d = r_upd;
        y_d = base_q;
      end else begin
        x_d = r_upd;
        y_d = r_upd;
      end
    end else if (cmd_i.mul_step) begin
      acc_d  = acc_next;
      y_d    = {y_q[MOD_BITS-2:0], 1'b0};
      mcnt_d = mcnt_q + MCW'(1);
    end
  end

  // Base, result and exponent registers.
  always_comb begin
    base_d = base_q;
    res_d  = res_q;
    exp_d  = exp_q;
    ecnt_d = ecnt_q;
    if (cmd_i.load) begin
      base_d = base_i;
      res_d  = one_m;
      exp_d  = exp_i;
      ecnt_d = '0;
    end else begin
      if (cmd_i.commit_base) begin
        base_d = acc_next;
      end
      if (cmd_i.commit_res) begin
        res_d = acc_next;
      end
      if (cmd_i.exp_next) begin
        exp_d  = exp_q << 1;
        ecnt_d = ecnt_q + ECW'(1);
      end
    end
  end

  // Output register; a zero modulus answers zero.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = (mod_q == '0) ? '0 : res_q;
    end
  end

  assign sts_o.mul_last = (mcnt_q == MCW'(MOD_BITS - 1));
  assign sts_o.exp_bit  = exp_q[EXP_BITS-1];
  assign sts_o.exp_last = (ecnt_q == ECW'(EXP_BITS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MOD_BITS'(2);
      out_valid_q <= 1'b0;
      mcnt_q      <= '0;
      ecnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      mcnt_q      <= mcnt_d;
      ecnt_q      <= ecnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    x_q        <= x_d;
    y_q        <= y_d;
    base_q     <= base_d;
    res_q      <= res_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  // The accumulator stays reduced while the multiplier runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_step && !mul_start && (mod_q != '0) |-> acc_q < mod_q)
    else $error("multiplier accumulator not reduced");

  // The running result stays reduced during the loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_step && (mod_q != '0) |-> res_q < mod_q)
    else $error("running result not reduced");

  // A result is never written over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten");

endmodule

`default_nettype wire

[design/modular_exponentiation_core.sv]
// Top level of the modular exponentiation core: stream ports, controller and datapath.
//
// Channel  Direction  Contents
// s_axis   in         tdata: base_value, exponent_value (zero padded to bytes)
// m_axis   out        tdata: power_result (zero padded to bytes)
// cfg      in         cfg_we_i / cfg_wdata_i: modulus
//
// One word first reduces the base, then squares the running result once per exponent bit
// and multiplies it by the base for each set exponent bit, then hands the result to the
// output register.
// The shared shift-add multiplier does all of these, one multiplier bit a cycle.
// Reset sets the modulus to 2 and empties the output register.
// A stalled output holds the result; a new word is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_core #(
  parameter int MOD_BITS = 27,
  parameter int EXP_BITS = 10
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_we_i,
  input  wire logic [MOD_BITS-1:0]                        cfg_wdata_i,
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  // tdata from bit 0: base_value, exponent_value
  input  wire logic [((MOD_BITS+EXP_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  // tdata from bit 0: power_result
  output logic [((MOD_BITS+7)/8)*8-1:0]                   m_axis_tdata
);

  localparam int OUT_W = ((MOD_BITS + 7) / 8) * 8;

  mexp_pkg::cmd_t      cmd;
  mexp_pkg::sts_t      sts;
  logic [MOD_BITS-1:0] result;

  // Sequencer.
  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  mexp_dpath #(
    .MOD_BITS (MOD_BITS),
    .EXP_BITS (EXP_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .base_i      (s_axis_tdata[MOD_BITS-1:0]),
    .exp_i       (s_axis_tdata[MOD_BITS+EXP_BITS-1:MOD_BITS]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (result)
  );

  // Pad the result with zeros to whole bytes.
  assign m_axis_tdata = OUT_W'(result);

endmodule

`default_nettype wire

[dv/mexp_power_checker.sv]
// Checker for the modular exponentiation core: predicts each power and compares the results.
`timescale 1ns / 1ps

module mexp_power_checker #(
  parameter int MOD_BITS = 27,
  parameter int EXP_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [MOD_BITS-1:0]                    cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  input  logic                                   s_axis_tready,
  // tdata from bit 0: base_value, exponent_value
  input  logic [((MOD_BITS+EXP_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata from bit 0: power_result
  input  logic [((MOD_BITS+7)/8)*8-1:0]          m_axis_tdata,
  output int                                     mismatch_count_o,
  output int                                     pending_o
);

  // One accepted word together with the power it must produce.
  typedef struct {
    logic [MOD_BITS-1:0] base;
    logic [EXP_BITS-1:0] exponent;
    logic [MOD_BITS-1:0] modulus;
    logic [MOD_BITS-1:0] power;
  } power_job_t;

  power_job_t          power_q[$];
  logic [MOD_BITS-1:0] modulus_copy;

  // Left-to-right square-and-multiply, reducing after every product.
  // Operands stay below the modulus, so each product fits in 64 bits.
  function automatic logic [MOD_BITS-1:0] expected_power(input logic [MOD_BITS-1:0] base,
                                                          input logic [EXP_BITS-1:0] exponent,
                                                          input logic [MOD_BITS-1:0] modulus);
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] r;
    int          i;
    if (modulus == '0) begin
      return '0;
    end
    m = 64'(modulus);
    b = 64'(base) % m;
    r = 64'd1 % m;
    for (i = EXP_BITS - 1; i >= 0; i--) begin
      r = (r * r) % m;
      if (exponent[i]) begin
        r = (r * b) % m;
      end
    end
    return r[MOD_BITS-1:0];
  endfunction

  // Track the modulus, queue a prediction per input word and match each output word.
  always @(posedge clk_i or negedge rst_ni) begin : track_words
    power_job_t          job;
    logic [MOD_BITS-1:0] got;
    if (!rst_ni) begin
      modulus_copy = MOD_BITS'(2);
      power_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        modulus_copy = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        job.base     = s_axis_tdata[MOD_BITS-1:0];
        job.exponent = s_axis_tdata[MOD_BITS +: EXP_BITS];
        job.modulus  = modulus_copy;
        job.power    = expected_power(job.base, job.exponent, job.modulus);
        power_q.push_back(job);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[MOD_BITS-1:0];
        if (power_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: unexpected word, power_result %0d with nothing pending",
                     $realtime, got);
          end
        end else begin
          job = power_q.pop_front();
          if (got !== job.power) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: power_result mismatch, base %0d exp %0d mod %0d: exp %0d got %0d",
                       $realtime, job.base, job.exponent, job.modulus, job.power, got);
            end
          end
        end
      end
      pending_o <= power_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
// Testbench top for the modular exponentiation core: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int MOD_BITS = 27;
  localparam int EXP_BITS = 10;
  localparam int S_W      = ((MOD_BITS + EXP_BITS + 7) / 8) * 8;
  localparam int M_W      = ((MOD_BITS + 7) / 8) * 8;
  localparam int PAD_W    = S_W - MOD_BITS - EXP_BITS;
  localparam logic [MOD_BITS-1:0] MOD_MAX   = '1;
  localparam logic [MOD_BITS-1:0] BIG_PRIME = MOD_BITS'(134217689);
  localparam logic [EXP_BITS-1:0] EXP_MAX   = '1;
  localparam int WORDS_PER_PHASE = 125;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORD_LATENCY    = 600;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [MOD_BITS-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_W-1:0]      s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_W-1:0]      m_axis_tdata;

  int                  mismatch_count;
  int                  pending_words;
  logic [MOD_BITS-1:0] current_modulus = MOD_BITS'(2);
  bit                  long_hold_req   = 1'b0;

  modular_exponentiation_core #(
    .MOD_BITS(MOD_BITS),
    .EXP_BITS(EXP_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  mexp_power_checker #(
    .MOD_BITS(MOD_BITS),
    .EXP_BITS(EXP_BITS)
  ) u_power_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_words)
  );

  // 100 MHz clock.
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle length: mostly none or short, a few long.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(50, 300);
  endfunction

  // Base mix: zero, all ones, tiny values, values at and just below the modulus and full random.
  function automatic logic [MOD_BITS-1:0] pick_base();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return '0;
    end else if (pick < 20) begin
      return MOD_MAX;
    end else if (pick < 30) begin
      return MOD_BITS'($urandom_range(0, 15));
    end else if (pick < 40) begin
      return current_modulus - MOD_BITS'($urandom_range(0, 1));
    end
    return MOD_BITS'($urandom);
  endfunction

  function automatic logic [EXP_BITS-1:0] pick_exponent();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return '0;
    end else if (pick < 15) begin
      return EXP_MAX;
    end else if (pick < 20) begin
      return EXP_BITS'(1);
    end
    return EXP_BITS'($urandom);
  endfunction

  // Offer one word after a random gap; valid stays high for a back-to-back follower.
  task automatic send_word(input logic [MOD_BITS-1:0] base,
                           input logic [EXP_BITS-1:0] exponent);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_W'({$urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, exponent, base};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Change the modulus once every pending word has come back.
  task automatic set_modulus(input logic [MOD_BITS-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    cfg_we_i        <= 1'b1;
    cfg_wdata_i     <= value;
    current_modulus  = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= MOD_BITS'($urandom);
  endtask

  // Result side: runs of ready with random stalls, plus one long hold on request.
  initial begin : result_sink
    int stall_left;
    int run_left;
    int hold_left;
    bit hold_taken;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 4000;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        m_axis_tready <= 1'b1;
      end else begin
        run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(2000, 5000)
                                                 : $urandom_range(1, 50);
        stall_left = idle_cycles();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed words per modulus, random phases, drain and verdict.
  initial begin : stimulus
    int  phase;
    int  n;
    int  waited;
    bit  drained;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset modulus of two.
    send_word(MOD_BITS'(5), EXP_BITS'(3));
    send_word(MOD_MAX, EXP_MAX);
    send_word(MOD_BITS'(4), '0);

    // Largest modulus: field extremes and alternating exponent bits.
    set_modulus(MOD_MAX);
    send_word('0, '0);
    send_word('0, EXP_MAX);
    send_word(MOD_MAX, EXP_BITS'(1));
    send_word(MOD_MAX, EXP_MAX);
    send_word(MOD_BITS'(1), EXP_MAX);
    send_word(MOD_MAX - MOD_BITS'(1), EXP_BITS'(2));
    send_word(MOD_BITS'(12345), EXP_BITS'(10'h2AA));
    send_word(MOD_BITS'(7654321), EXP_BITS'(10'h155));

    // Prime modulus with bases at, above and below it.
    set_modulus(BIG_PRIME);
    send_word(BIG_PRIME, EXP_BITS'(1));
    send_word(MOD_MAX, EXP_BITS'(1));
    send_word(MOD_BITS'(2), EXP_MAX);

    // Modulus of one: every result is zero, even for a zero exponent.
    set_modulus(MOD_BITS'(1));
    send_word(MOD_BITS'(5), '0);
    send_word(MOD_MAX, EXP_MAX);

    // Modulus of zero: no reduction possible, the answer is zero.
    set_modulus('0);
    send_word(MOD_BITS'(9), EXP_BITS'(5));
    send_word('0, '0);

    // Smallest legal modulus written explicitly.
    set_modulus(MOD_BITS'(2));
    send_word(MOD_BITS'(3), EXP_BITS'(7));
    send_word(MOD_BITS'(2), '0);

    // Random phases, each under its own modulus.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_modulus(MOD_MAX);
        1:       set_modulus(MOD_BITS'(2));
        2:       set_modulus(MOD_BITS'($urandom_range(2, 255)));
        default: set_modulus(MOD_BITS'($urandom_range(2, int'(MOD_MAX))));
      endcase
      if (phase == 3) begin
        long_hold_req = 1'b1;
      end
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(pick_base(), pick_exponent());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let every expected word come back, then watch for stray output.
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_words != 0 && waited < 20000);
    drained = (pending_words == 0);
    repeat (WORD_LATENCY) @(posedge clk_i);

    if (mismatch_count == 0 && drained) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mexp_pkg.sv
design/mexp_ctrl.sv
design/mexp_dpath.sv
design/modular_exponentiation_core.sv
dv/mexp_power_checker.sv
dv/tb_top.sv
